// File: sv/sjf_job_scheduler_with_stats_assert.svh
// Assertion macros for the scheduler
`ifndef SJF_JOB_SCHEDULER_WITH_STATS_ASSERT_SVH
`define SJF_JOB_SCHEDULER_WITH_STATS_ASSERT_SVH
// implication checked every clock outside reset
`define SJF_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define SJF_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/sjf_pkg.sv
package sjf_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic        ReqTick = 1'b0;
  localparam logic        ReqArrive = 1'b1;
  localparam logic        StDone = 1'b0;
  localparam logic        StDrop = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input beat
    logic enqueue;     // write captured arrival at tail
    logic tick;        // advance clock, count down
    logic scan_step;   // examine one slot
    logic take;        // move best slot to server
    logic shift_step;  // compact one slot
    logic finish;      // update group totals, load result
    logic drop;        // load drop result
    logic out_load;    // result register valid
  } sjf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_arrival;
    logic full;
    logic empty;
    logic busy;
    logic last_tick;   // running job ends on this tick
    logic scan_end;
    logic shift_end;
  } sjf_sts_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction
endpackage

// File: sv/sjf_ctrl.sv
module sjf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sjf_pkg::sjf_sts_t sts,
  output sjf_pkg::sjf_cmd_t cmd
);
  import sjf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_OUT} state_t;
  state_t state;
  logic   ovalid;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = ovalid;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load_in = in_valid;
      S_DECODE: begin
        if (sts.is_arrival) begin
          if (sts.full) cmd.drop = 1'b1;
          else cmd.enqueue = 1'b1;
        end else begin
          cmd.tick = 1'b1;
          if (sts.busy && sts.last_tick) cmd.finish = 1'b1;
        end
      end
      S_SCAN:   begin
        if (sts.scan_end) cmd.take = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      S_SHIFT:  cmd.shift_step = !sts.shift_end;
      S_OUT:    ;
      default:  ;
    endcase
    cmd.out_load = cmd.drop | cmd.finish;
  end

  // after decode: dispatch if server free (after finish) and queue nonempty
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (cmd.out_load) ovalid <= 1'b1;
      else if (!out_stall) ovalid <= 1'b0;
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          if (sts.is_arrival && sts.full) state <= S_OUT;
          else if (sts.is_arrival && !sts.busy) state <= S_SCAN;
          else if (!sts.is_arrival && sts.busy && sts.last_tick && !sts.empty)
            state <= S_SCAN;
          else state <= S_OUT;
        end
        S_SCAN:   if (sts.scan_end) state <= S_SHIFT;
        S_SHIFT:  if (sts.shift_end) state <= S_OUT;
        S_OUT:    if (!ovalid || !out_stall) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/sjf_dp.sv
module sjf_dp #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::QueueDepthDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_type,
  input  logic [15:0]       job_id,
  input  logic [15:0]       job_size,
  input  logic              group,
  input  sjf_pkg::sjf_cmd_t cmd,
  output sjf_pkg::sjf_sts_t sts,
  output logic              status,
  output logic [15:0]       done_id,
  output logic              done_group,
  output logic [31:0]       wait_ticks,
  output logic [31:0]       latency_ticks,
  output logic [31:0]       group_jobs,
  output logic [47:0]       group_wait_sum,
  output logic [47:0]       group_latency_sum,
  output logic [47:0]       group_exec_sum
);
  import sjf_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = CW + 1;

  // queue memory, one record per slot: {group, id, size, arrival}
  logic [64:0] mem [QUEUE_DEPTH];
  logic [64:0] rd_q;
  logic [CW-1:0] count;
  logic [PW-1:0] ptr;      // scan / shift index
  logic [IW-1:0] best;
  logic [15:0]   best_size;
  logic          rd_ok;    // rd_q holds slot ptr-1
  logic [64:0]   best_rec; // record of the best slot so far
  logic          better;   // rd_q beats the best so far (slot 0 always does)

  logic        a_type, a_grp;
  logic [15:0] a_id, a_size;

  logic [31:0] now_ticks;
  logic        busy;
  logic [16:0] run_job;
  logic [15:0] run_left, run_size;
  logic [31:0] run_arr, run_start;
  logic [31:0] g_cnt [2];
  logic [47:0] g_wait [2], g_lat [2], g_exec [2];

  logic [31:0] now_inc, w, l;
  logic        g;
  assign now_inc = now_ticks + 32'd1;
  assign g  = run_job[16];
  assign w  = run_start - run_arr;
  assign l  = now_inc - run_arr;
  assign better = (ptr == PW'(1)) || (rd_q[47:32] < best_size);

  assign sts.is_arrival = (a_type == ReqArrive);
  assign sts.full       = (count == CW'(QUEUE_DEPTH));
  assign sts.empty      = (count == '0);
  assign sts.busy       = busy;
  assign sts.last_tick  = (run_left <= 16'd1);
  assign sts.scan_end   = rd_ok && (ptr == PW'(count));
  assign sts.shift_end  = (ptr >= PW'(count) + PW'(2));

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.enqueue)
      mem[count[IW-1:0]] <= {a_grp, a_id, (a_size == 16'd0) ? 16'd1 : a_size, now_ticks};
    else if (cmd.shift_step && rd_ok)
      mem[IW'(ptr - PW'(2))] <= rd_q;
    rd_q <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_type <= req_type; a_id <= job_id; a_size <= job_size; a_grp <= group;
    end
    if (rst) begin
      count <= '0; ptr <= '0; rd_ok <= 1'b0; best <= '0; best_size <= '0;
      now_ticks <= '0; busy <= 1'b0; run_job <= '0; run_left <= '0;
      run_size <= '0; run_arr <= '0; run_start <= '0;
      for (int i = 0; i < 2; i++) begin
        g_cnt[i] <= '0; g_wait[i] <= '0; g_lat[i] <= '0; g_exec[i] <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        ptr <= '0; rd_ok <= 1'b0; best_size <= 16'hFFFF; best <= '0;
      end
      if (cmd.enqueue) count <= count + CW'(1);
      if (cmd.tick) begin
        now_ticks <= now_inc;
        if (busy && run_left != 16'd0 && !cmd.finish) run_left <= run_left - 16'd1;
      end
      if (cmd.finish) begin
        busy <= 1'b0;
        run_left <= '0;
        if (g_cnt[g] != 32'hFFFF_FFFF) g_cnt[g] <= g_cnt[g] + 32'd1;
        g_wait[g] <= sat_add48(g_wait[g], w);
        g_lat[g]  <= sat_add48(g_lat[g], l);
        g_exec[g] <= sat_add48(g_exec[g], {16'd0, run_size});
      end
      if (cmd.scan_step) begin
        // rd_q shows slot ptr-1 once rd_ok
        if (rd_ok && better) begin
          best_size <= rd_q[47:32];
          best <= IW'(ptr - PW'(1));
        end
        if (ptr != PW'(count)) ptr <= ptr + PW'(1);
        rd_ok <= 1'b1;
      end
      if (cmd.take) begin
        // last slot still in rd_q
        busy <= 1'b1;
        if (better) begin
          run_job <= rd_q[64:48]; run_size <= rd_q[47:32];
          run_left <= rd_q[47:32]; run_arr <= rd_q[31:0];
          ptr <= PW'(count) + PW'(1);
        end else begin
          run_job <= best_rec[64:48]; run_size <= best_rec[47:32];
          run_left <= best_rec[47:32]; run_arr <= best_rec[31:0];
          ptr <= PW'(best) + PW'(1);
        end
        rd_ok <= 1'b0;
        run_start <= now_ticks;
        count <= count - CW'(1);
      end
      if (cmd.shift_step) begin
        ptr <= ptr + PW'(1);
        rd_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      status <= StDrop; done_id <= a_id; done_group <= a_grp;
      wait_ticks <= '0; latency_ticks <= '0; group_jobs <= '0;
      group_wait_sum <= '0; group_latency_sum <= '0; group_exec_sum <= '0;
    end else if (cmd.finish) begin
      status <= StDone; done_id <= run_job[15:0]; done_group <= g;
      wait_ticks <= w; latency_ticks <= l;
      group_jobs <= (g_cnt[g] != 32'hFFFF_FFFF) ? g_cnt[g] + 32'd1 : g_cnt[g];
      group_wait_sum <= sat_add48(g_wait[g], w);
      group_latency_sum <= sat_add48(g_lat[g], l);
      group_exec_sum <= sat_add48(g_exec[g], {16'd0, run_size});
    end
  end

  // the best record is captured during the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_ok && better) best_rec <= rd_q;
  end
endmodule

// File: sv/sjf_job_scheduler_with_stats.sv
// channel | handshake           | payload
// in      | in_valid / in_stall  | req_type job_id job_size group
// out     | out_valid / out_stall| status done_id done_group wait/latency/group stats
// When a job starts, the queue is scanned for the minimum through the single
// registered queue read port, and then the queue is compacted.
// Reset is synchronous; the queue is empty and all totals are zero after it.
// The result sits in an output register; out_stall holds the next item off.
module sjf_job_scheduler_with_stats #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] job_id,
  input  logic [15:0] job_size,
  input  logic        group,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [15:0] done_id,
  output logic        done_group,
  output logic [31:0] wait_ticks,
  output logic [31:0] latency_ticks,
  output logic [31:0] group_jobs,
  output logic [47:0] group_wait_sum,
  output logic [47:0] group_latency_sum,
  output logic [47:0] group_exec_sum
);
  import sjf_pkg::*;
  `include "sjf_job_scheduler_with_stats_assert.svh"

  sjf_cmd_t cmd;
  sjf_sts_t sts;

  sjf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  sjf_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst, .req_type, .job_id, .job_size, .group, .cmd, .sts,
    .status, .done_id, .done_group, .wait_ticks, .latency_ticks, .group_jobs,
    .group_wait_sum, .group_latency_sum, .group_exec_sum
  );

  // a finished job clears the registered busy flag
  `SJF_ASSERT_NXT(a_finish_idle, cmd.finish, !sts.busy)
  // never enqueue into a full queue
  `SJF_ASSERT_IMP(a_no_overfill, cmd.enqueue, !sts.full)
  // a result is loaded only while no item is being accepted
  `SJF_ASSERT_IMP(a_load_stalled, cmd.out_load, in_stall)
endmodule
